// ----- src/tmvg_pkg.sv -----
// Shared types, constants and helpers for the torus mesh vertex generator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package tmvg_pkg;

	localparam int MAX_SUBDIV   = 1024;
	localparam int CNT_W        = 10;
	localparam int IDX_W        = 10;
	localparam int RAD_W        = 16;
	localparam int POS_W        = 17;
	localparam int NORM_W       = 16;
	localparam int TEX_W        = 17;
	localparam int TEX_FRAC     = 16;
	localparam int ANG_W        = 32;
	localparam int CORDIC_STEPS = 16;
	localparam int CFG_IDX_W    = 2;

	// Latency of the fraction divider and of the sine/cosine unit in cycles.
	localparam int DIV_LAT = ANG_W + 2;
	localparam int SC_LAT  = CORDIC_STEPS + 2;

	localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(3);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SUBDIV - 1);
	localparam logic [TEX_W-1:0] TEX_ONE = TEX_W'(1 << TEX_FRAC);

	// CORDIC start vector: gain-compensated unit length in Q2.30.
	localparam logic signed [ANG_W-1:0] CORDIC_X0 = 32'sd652032874;

	// atan(2^-i) as a fraction of a full turn, 2^32 per turn.
	localparam logic signed [ANG_W-1:0] ATAN_TURN [CORDIC_STEPS] = '{
		32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
		32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
		32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
		32'sd166886,    32'sd83443,     32'sd41721,     32'sd20861
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INNER_RADIUS = 2'd0,
		REG_OUTER_RADIUS = 2'd1,
		REG_SLICE_COUNT  = 2'd2,
		REG_STACK_COUNT  = 2'd3
	} cfg_reg_t;

	// Subdivision counts are held in their usable range.
	function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
		logic [CNT_W-1:0] r;
		r = c;
		if (c < CNT_MIN) begin
			r = CNT_MIN;
		end else if (c > CNT_MAX) begin
			r = CNT_MAX;
		end
		return r;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [31:0] v);
		logic signed [POS_W-1:0] r;
		r = v[POS_W-1:0];
		if (v > 32'sd65535) begin
			r = 17'sd65535;
		end else if (v < -32'sd65536) begin
			r = -17'sd65536;
		end
		return r;
	endfunction

	function automatic logic signed [NORM_W-1:0] sat_norm(input logic signed [31:0] v);
		logic signed [NORM_W-1:0] r;
		r = v[NORM_W-1:0];
		if (v > 32'sd32767) begin
			r = 16'sd32767;
		end else if (v < -32'sd32768) begin
			r = -16'sd32768;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- src/tmvg_in_if.sv -----
// Request channel of the torus vertex generator: one grid vertex per item.
// Depends on tmvg_pkg for field widths.
`default_nettype none

interface tmvg_in_if import tmvg_pkg::*;;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] stack_index;
	logic [IDX_W-1:0] slice_index;

	modport source (output valid, output stack_index, output slice_index, input ready);
	modport sink   (input valid, input stack_index, input slice_index, output ready);
endinterface

`default_nettype wire

// ----- src/tmvg_out_if.sv -----
// Result channel of the torus vertex generator: position, normal, texture.
// Depends on tmvg_pkg for field widths.
`default_nettype none

interface tmvg_out_if import tmvg_pkg::*;;
	logic                     valid;
	logic                     ready;
	logic signed [POS_W-1:0]  pos_x;
	logic signed [POS_W-1:0]  pos_y;
	logic signed [POS_W-1:0]  pos_z;
	logic signed [NORM_W-1:0] norm_x;
	logic signed [NORM_W-1:0] norm_y;
	logic signed [NORM_W-1:0] norm_z;
	logic [TEX_W-1:0]         tex_u;
	logic [TEX_W-1:0]         tex_v;

	modport source (output valid, output pos_x, output pos_y, output pos_z,
		output norm_x, output norm_y, output norm_z, output tex_u, output tex_v,
		input ready);
	modport sink   (input valid, input pos_x, input pos_y, input pos_z,
		input norm_x, input norm_y, input norm_z, input tex_u, input tex_v,
		output ready);
endinterface

`default_nettype wire

// ----- src/torus_mesh_vertex_gen_core.sv -----
// Top level of the torus vertex generator: configuration, flow control, products.
// Depends on tmvg_pkg, tmvg_in_if, tmvg_out_if, tmvg_frac_div and tmvg_sincos.
//
//  Channel    Direction  Handshake          Carries
//  vtx_in     sink       valid/ready        stack_index, slice_index
//  vtx_out    source     valid/ready        pos_x/y/z, norm_x/y/z, tex_u, tex_v
//  cfg_*      sink       cfg_we only        cfg_index, cfg_wdata
//
// One item enters per cycle unless a result waits unaccepted on vtx_out; the
// depth is set by the fraction divider (one quotient bit per stage, 34 stages),
// the CORDIC unit (18 stages) and four multiply and round stages.
// Reset clears the valid bits and loads the register defaults; no clearing
// pass is needed, so the block takes items from the first cycle after reset.
// A stall on vtx_out freezes the whole pipeline; empty stages keep advancing
// until a valid result sits at the output, so nothing is lost or repeated.
`default_nettype none

module torus_mesh_vertex_gen_core import tmvg_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [RAD_W-1:0]     cfg_wdata,
	tmvg_in_if.sink                   vtx_in,
	tmvg_out_if.source                vtx_out
);

	localparam int LAT = DIV_LAT + SC_LAT + 4;

	// Configuration registers; the counts are held already clamped.
	logic [RAD_W-1:0] inner_q;
	logic [RAD_W-1:0] outer_q;
	logic [CNT_W-1:0] slices_q;
	logic [CNT_W-1:0] stacks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_q  <= RAD_W'(256);
			outer_q  <= RAD_W'(512);
			slices_q <= CNT_W'(32);
			stacks_q <= CNT_W'(16);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_INNER_RADIUS: inner_q  <= cfg_wdata;
				REG_OUTER_RADIUS: outer_q  <= cfg_wdata;
				REG_SLICE_COUNT:  slices_q <= eff_count(cfg_wdata[CNT_W-1:0]);
				REG_STACK_COUNT:  stacks_q <= eff_count(cfg_wdata[CNT_W-1:0]);
				default: ;
			endcase
		end
	end

	// Flow control: every stage moves together unless the output is full
	// and not being taken.
	logic [LAT-1:0] vld_s;
	logic           adv;

	assign adv          = !vld_s[LAT-1] || vtx_out.ready;
	assign vtx_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (adv) begin
			vld_s <= {vld_s[LAT-2:0], vtx_in.valid};
		end
	end

	// Indices beyond the count are clamped to the count itself.
	logic [CNT_W-1:0] slice_sat;
	logic [CNT_W-1:0] stack_sat;

	assign slice_sat = (vtx_in.slice_index > slices_q) ? slices_q : vtx_in.slice_index;
	assign stack_sat = (vtx_in.stack_index > stacks_q) ? stacks_q : vtx_in.stack_index;

	logic [ANG_W-1:0] phase_u;
	logic [ANG_W-1:0] phase_v;
	logic [TEX_W-1:0] tex_u_div;
	logic [TEX_W-1:0] tex_v_div;

	tmvg_frac_div u_div_slice (
		.clk   (clk),
		.en    (adv),
		.idx   (slice_sat),
		.cnt   (slices_q),
		.phase (phase_u),
		.tex   (tex_u_div)
	);

	tmvg_frac_div u_div_stack (
		.clk   (clk),
		.en    (adv),
		.idx   (stack_sat),
		.cnt   (stacks_q),
		.phase (phase_v),
		.tex   (tex_v_div)
	);

	logic signed [ANG_W-1:0] cu;
	logic signed [ANG_W-1:0] su;
	logic signed [ANG_W-1:0] cv;
	logic signed [ANG_W-1:0] sv;

	tmvg_sincos u_sc_ring (
		.clk     (clk),
		.en      (adv),
		.phase   (phase_u),
		.cos_val (cu),
		.sin_val (su)
	);

	// The tube angle starts at minus a half turn: adding a half turn is a
	// flip of the top phase bit.
	tmvg_sincos u_sc_tube (
		.clk     (clk),
		.en      (adv),
		.phase   ({~phase_v[ANG_W-1], phase_v[ANG_W-2:0]}),
		.cos_val (cv),
		.sin_val (sv)
	);

	// Texture values wait alongside the CORDIC units.
	logic [TEX_W-1:0] tu_dly_s [0:SC_LAT-1];
	logic [TEX_W-1:0] tv_dly_s [0:SC_LAT-1];

	always_ff @(posedge clk) begin
		if (adv) begin
			tu_dly_s[0] <= tex_u_div;
			tv_dly_s[0] <= tex_v_div;
			for (int k = 1; k < SC_LAT; k++) begin
				tu_dly_s[k] <= tu_dly_s[k-1];
				tv_dly_s[k] <= tv_dly_s[k-1];
			end
		end
	end

	// Ring radius sum and tube radius, both in Q.9 (twice the true radius).
	logic [RAD_W:0]        rc9;
	logic signed [RAD_W:0] rt9;

	assign rc9 = {1'b0, inner_q} + {1'b0, outer_q};
	assign rt9 = signed'({1'b0, outer_q}) - signed'({1'b0, inner_q});

	// Stage 52: first products.
	logic signed [48:0]        rcv_s52;
	logic signed [48:0]        rsv_s52;
	logic signed [63:0]        nxp_s52;
	logic signed [63:0]        nyp_s52;
	logic signed [ANG_W-1:0]   cu_s52;
	logic signed [ANG_W-1:0]   su_s52;
	logic signed [ANG_W-1:0]   sv_s52;
	logic [TEX_W-1:0]          tu_s52;
	logic [TEX_W-1:0]          tv_s52;

	always_ff @(posedge clk) begin
		if (adv) begin
			rcv_s52 <= rt9 * cv;
			rsv_s52 <= rt9 * sv;
			nxp_s52 <= cu * cv;
			nyp_s52 <= su * cv;
			cu_s52  <= cu;
			su_s52  <= su;
			sv_s52  <= sv;
			tu_s52  <= tu_dly_s[SC_LAT-1];
			tv_s52  <= tv_dly_s[SC_LAT-1];
		end
	end

	// Stage 53: ring distance R + r cos v in Q.16, normals and z rounded.
	logic signed [49:0] ring_sum;
	logic signed [63:0] pz_r;
	logic signed [63:0] nx_r;
	logic signed [63:0] ny_r;
	logic signed [63:0] nz_r;

	assign ring_sum = signed'(50'({rc9, 30'b0})) + 50'(rcv_s52) + (50'sd1 <<< 22);
	assign pz_r     = (64'(rsv_s52) + (64'sd1 <<< 30)) >>> 31;
	assign nx_r     = (nxp_s52 + (64'sd1 <<< 44)) >>> 45;
	assign ny_r     = (nyp_s52 + (64'sd1 <<< 44)) >>> 45;
	assign nz_r     = (64'(sv_s52) + (64'sd1 <<< 14)) >>> 15;

	logic signed [26:0]        ring_s53;
	logic signed [POS_W-1:0]   pz_s53;
	logic signed [NORM_W-1:0]  nx_s53;
	logic signed [NORM_W-1:0]  ny_s53;
	logic signed [NORM_W-1:0]  nz_s53;
	logic signed [ANG_W-1:0]   cu_s53;
	logic signed [ANG_W-1:0]   su_s53;
	logic [TEX_W-1:0]          tu_s53;
	logic [TEX_W-1:0]          tv_s53;

	always_ff @(posedge clk) begin
		if (adv) begin
			ring_s53 <= ring_sum[49:23];
			pz_s53   <= sat_pos(pz_r[31:0]);
			nx_s53   <= sat_norm(nx_r[31:0]);
			ny_s53   <= sat_norm(ny_r[31:0]);
			nz_s53   <= sat_norm(nz_r[31:0]);
			cu_s53   <= cu_s52;
			su_s53   <= su_s52;
			tu_s53   <= tu_s52;
			tv_s53   <= tv_s52;
		end
	end

	// Stage 54: ring distance times the ring angle's cosine and sine.
	logic signed [58:0]        pxp_s54;
	logic signed [58:0]        pyp_s54;
	logic signed [POS_W-1:0]   pz_s54;
	logic signed [NORM_W-1:0]  nx_s54;
	logic signed [NORM_W-1:0]  ny_s54;
	logic signed [NORM_W-1:0]  nz_s54;
	logic [TEX_W-1:0]          tu_s54;
	logic [TEX_W-1:0]          tv_s54;

	always_ff @(posedge clk) begin
		if (adv) begin
			pxp_s54 <= ring_s53 * cu_s53;
			pyp_s54 <= ring_s53 * su_s53;
			pz_s54  <= pz_s53;
			nx_s54  <= nx_s53;
			ny_s54  <= ny_s53;
			nz_s54  <= nz_s53;
			tu_s54  <= tu_s53;
			tv_s54  <= tv_s53;
		end
	end

	// Stage 55: round x and y to Q.8 and saturate; this is the output register.
	logic signed [58:0] px_r;
	logic signed [58:0] py_r;

	assign px_r = (pxp_s54 + (59'sd1 <<< 37)) >>> 38;
	assign py_r = (pyp_s54 + (59'sd1 <<< 37)) >>> 38;

	logic signed [POS_W-1:0]   px_s55;
	logic signed [POS_W-1:0]   py_s55;
	logic signed [POS_W-1:0]   pz_s55;
	logic signed [NORM_W-1:0]  nx_s55;
	logic signed [NORM_W-1:0]  ny_s55;
	logic signed [NORM_W-1:0]  nz_s55;
	logic [TEX_W-1:0]          tu_s55;
	logic [TEX_W-1:0]          tv_s55;

	always_ff @(posedge clk) begin
		if (adv) begin
			px_s55 <= sat_pos(px_r[31:0]);
			py_s55 <= sat_pos(py_r[31:0]);
			pz_s55 <= pz_s54;
			nx_s55 <= nx_s54;
			ny_s55 <= ny_s54;
			nz_s55 <= nz_s54;
			tu_s55 <= tu_s54;
			tv_s55 <= tv_s54;
		end
	end

	assign vtx_out.valid  = vld_s[LAT-1];
	assign vtx_out.pos_x  = px_s55;
	assign vtx_out.pos_y  = py_s55;
	assign vtx_out.pos_z  = pz_s55;
	assign vtx_out.norm_x = nx_s55;
	assign vtx_out.norm_y = ny_s55;
	assign vtx_out.norm_z = nz_s55;
	assign vtx_out.tex_u  = tu_s55;
	assign vtx_out.tex_v  = tv_s55;

	// The stored counts always lie in the range the divider relies on.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(slices_q >= CNT_MIN) && (stacks_q >= CNT_MIN))
		else $error("subdivision count below minimum");

	// The request side is held off only while a result waits unaccepted.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!vtx_in.ready |-> (vtx_out.valid && !vtx_out.ready))
		else $error("request stalled without a blocked result");

	// Texture fractions never exceed one.
	a_tex_range: assert property (@(posedge clk) disable iff (!arst_n)
		vtx_out.valid |-> (vtx_out.tex_u <= TEX_ONE) && (vtx_out.tex_v <= TEX_ONE))
		else $error("texture coordinate above one");

endmodule

`default_nettype wire

// ----- src/tmvg_frac_div.sv -----
// Pipelined fraction divider: idx/cnt as a rounded turn phase and texture value.
// Depends on tmvg_pkg; one quotient bit per stage, DIV_LAT stages in all.
`default_nettype none

module tmvg_frac_div import tmvg_pkg::*; (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [CNT_W-1:0] idx,
	input  wire logic [CNT_W-1:0] cnt,
	output logic [ANG_W-1:0]      phase,
	output logic [TEX_W-1:0]      tex
);

	logic [CNT_W-1:0] rem_s [0:ANG_W];
	logic [ANG_W:0]   quo_s [0:ANG_W];
	logic [TEX_W-1:0] tex_s [TEX_FRAC+1:ANG_W];
	logic [ANG_W-1:0] phase_s33;
	logic [TEX_W-1:0] tex_s33;

	logic [CNT_W:0]   dbl   [1:ANG_W];
	logic [CNT_W:0]   diff  [1:ANG_W];
	logic             ge    [1:ANG_W];
	logic [CNT_W-1:0] half;
	logic             rnd_tex;
	logic             rnd_phase;

	assign half = cnt >> 1;

	// Round half up: the remainder plus half the divisor reaching the divisor.
	assign rnd_tex   = ({1'b0, rem_s[TEX_FRAC]} + {1'b0, half}) >= {1'b0, cnt};
	assign rnd_phase = ({1'b0, rem_s[ANG_W]} + {1'b0, half}) >= {1'b0, cnt};

	always_comb begin
		for (int k = 1; k <= ANG_W; k++) begin
			dbl[k]  = {rem_s[k-1], 1'b0};
			diff[k] = dbl[k] - {1'b0, cnt};
			ge[k]   = dbl[k] >= {1'b0, cnt};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// The index never exceeds the count, so the integer part is one bit.
			quo_s[0] <= (ANG_W+1)'(idx == cnt);
			rem_s[0] <= (idx == cnt) ? '0 : idx;
			for (int k = 1; k <= ANG_W; k++) begin
				quo_s[k] <= {quo_s[k-1][ANG_W-1:0], ge[k]};
				rem_s[k] <= ge[k] ? diff[k][CNT_W-1:0] : dbl[k][CNT_W-1:0];
			end
			tex_s[TEX_FRAC+1] <= quo_s[TEX_FRAC][TEX_W-1:0] + TEX_W'(rnd_tex);
			for (int k = TEX_FRAC + 2; k <= ANG_W; k++) begin
				tex_s[k] <= tex_s[k-1];
			end
			phase_s33 <= quo_s[ANG_W][ANG_W-1:0] + ANG_W'(rnd_phase);
			tex_s33   <= tex_s[ANG_W];
		end
	end

	assign phase = phase_s33;
	assign tex   = tex_s33;

endmodule

`default_nettype wire

// ----- src/tmvg_sincos.sv -----
// Pipelined CORDIC sine and cosine of a 32-bit turn phase, results in Q2.30.
// Depends on tmvg_pkg; fold stage, one stage per rotation, sign-restore stage.
`default_nettype none

module tmvg_sincos import tmvg_pkg::*; (
	input  wire logic                    clk,
	input  wire logic                    en,
	input  wire logic [ANG_W-1:0]        phase,
	output logic signed [ANG_W-1:0]      cos_val,
	output logic signed [ANG_W-1:0]      sin_val
);

	localparam logic signed [ANG_W-1:0] QUARTER = 32'sh4000_0000;

	logic signed [ANG_W-1:0] cx_s [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] cy_s [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] cz_s [0:CORDIC_STEPS];
	logic                    flip_s [0:CORDIC_STEPS];
	logic signed [ANG_W-1:0] cos_s17;
	logic signed [ANG_W-1:0] sin_s17;

	logic signed [ANG_W-1:0] dx [1:CORDIC_STEPS];
	logic signed [ANG_W-1:0] dy [1:CORDIC_STEPS];
	logic signed [ANG_W-1:0] z_in;
	logic                    fold;

	// Angles beyond a quarter turn either way move by a half turn, which is
	// the top bit of the phase, and both results change sign at the end.
	assign z_in = signed'(phase);
	assign fold = (z_in > QUARTER) || (z_in < -QUARTER);

	always_comb begin
		for (int k = 1; k <= CORDIC_STEPS; k++) begin
			dx[k] = cy_s[k-1] >>> (k - 1);
			dy[k] = cx_s[k-1] >>> (k - 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0]   <= CORDIC_X0;
			cy_s[0]   <= '0;
			cz_s[0]   <= fold ? signed'({~phase[ANG_W-1], phase[ANG_W-2:0]}) : z_in;
			flip_s[0] <= fold;
			for (int k = 1; k <= CORDIC_STEPS; k++) begin
				if (!cz_s[k-1][ANG_W-1]) begin
					cx_s[k] <= cx_s[k-1] - dx[k];
					cy_s[k] <= cy_s[k-1] + dy[k];
					cz_s[k] <= cz_s[k-1] - ATAN_TURN[k-1];
				end else begin
					cx_s[k] <= cx_s[k-1] + dx[k];
					cy_s[k] <= cy_s[k-1] - dy[k];
					cz_s[k] <= cz_s[k-1] + ATAN_TURN[k-1];
				end
				flip_s[k] <= flip_s[k-1];
			end
			cos_s17 <= flip_s[CORDIC_STEPS] ? -cx_s[CORDIC_STEPS] : cx_s[CORDIC_STEPS];
			sin_s17 <= flip_s[CORDIC_STEPS] ? -cy_s[CORDIC_STEPS] : cy_s[CORDIC_STEPS];
		end
	end

	assign cos_val = cos_s17;
	assign sin_val = sin_s17;

endmodule

`default_nettype wire

// ----- tb/sv/tb_vertex_channels.sv -----
// Result record type shared by the testbench for one vertex item.
// Depends on tmvg_pkg for the field widths.
package tb_vertex_types;
	import tmvg_pkg::*;
	typedef struct packed {
		logic signed [POS_W-1:0]  pos_x;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [NORM_W-1:0] norm_x;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_z;
		logic [TEX_W-1:0]         tex_u;
		logic [TEX_W-1:0]         tex_v;
	} vertex_t;
endpackage

// ----- tb/sv/tb_torus_mesh_vertex_gen_core.sv -----
// Testbench for torus_mesh_vertex_gen_core: drives grid vertices, predicts each vertex.
// Depends on tmvg_pkg, tb_vertex_types and the channel interfaces of the block.
module tb_torus_mesh_vertex_gen_core;
	import tmvg_pkg::*;
	import tb_vertex_types::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PIPE_LAT = 56;
	localparam int STALL_LIMIT = 4000;

	// Scoreboard: predicts each vertex when its item is accepted and checks results in order.
	class vertex_scoreboard;
		logic [15:0] inner_q, outer_q;
		logic [9:0]  slices_q, stacks_q;
		vertex_t     pending_vertices[$];
		int          mismatches;

		function new();
			inner_q = 16'd256;
			outer_q = 16'd512;
			slices_q = 10'd32;
			stacks_q = 10'd16;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_reg_t r, logic [15:0] d);
			case (r)
				REG_INNER_RADIUS: inner_q = d;
				REG_OUTER_RADIUS: outer_q = d;
				REG_SLICE_COUNT:  slices_q = d[9:0];
				default:          stacks_q = d[9:0];
			endcase
		endfunction

		// Arithmetic (floor) shift of a signed 64-bit value.
		function longint shr(longint v, int s);
			return v >>> s;
		endfunction

		function longint rnd(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint clip(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function longint used_count(logic [9:0] c);
			if (c < 10'd3) return 3;
			if (c > 10'd1023) return 1023;
			return c;
		endfunction

		// Sine and cosine of a turn fraction by a 16-step CORDIC, Q2.30.
		task automatic cordic(input logic [31:0] phase, output longint c, output longint s);
			longint z, x, y, dx, dy;
			bit flip;
			z = phase;
			x = 652032874;
			y = 0;
			flip = 0;
			if (z >= (longint'(1) <<< 31)) z -= longint'(1) <<< 32;
			if (z > (longint'(1) <<< 30)) begin
				z -= longint'(1) <<< 31;
				flip = 1;
			end else if (z < -(longint'(1) <<< 30)) begin
				z += longint'(1) <<< 31;
				flip = 1;
			end
			for (int i = 0; i < 16; i++) begin
				dx = shr(y, i);
				dy = shr(x, i);
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= longint'(ATAN_TURN[i]);
				end else begin
					x += dx;
					y -= dy;
					z += longint'(ATAN_TURN[i]);
				end
			end
			if (flip) begin
				x = -x;
				y = -y;
			end
			c = x;
			s = y;
		endtask

		function logic [31:0] turn_of(longint idx, longint cnt);
			longint unsigned q;
			q = ((longint'(idx) <<< 32) + cnt / 2) / cnt;
			return q[31:0];
		endfunction

		task automatic note_request(input logic [9:0] stack_i, input logic [9:0] slice_i);
			longint ns, nt, jt, js, cu, su, cv, sv, rc, rt, ring;
			vertex_t v;
			ns = used_count(slices_q);
			nt = used_count(stacks_q);
			jt = stack_i > nt ? nt : stack_i;
			js = slice_i > ns ? ns : slice_i;
			cordic(turn_of(js, ns), cu, su);
			cordic(turn_of(jt, nt) + 32'h8000_0000, cv, sv);
			rc = longint'(inner_q) + longint'(outer_q);
			rt = longint'(outer_q) - longint'(inner_q);
			ring = rnd(rc * (longint'(1) <<< 30) + rt * cv, 23);
			v.pos_x = POS_W'(clip(rnd(ring * cu, 38), -65536, 65535));
			v.pos_y = POS_W'(clip(rnd(ring * su, 38), -65536, 65535));
			v.pos_z = POS_W'(clip(rnd(rt * sv, 31), -65536, 65535));
			v.norm_x = NORM_W'(clip(rnd(cu * cv, 45), -32768, 32767));
			v.norm_y = NORM_W'(clip(rnd(su * cv, 45), -32768, 32767));
			v.norm_z = NORM_W'(clip(rnd(sv, 15), -32768, 32767));
			v.tex_u = TEX_W'((js * 65536 + ns / 2) / ns);
			v.tex_v = TEX_W'((jt * 65536 + nt / 2) / nt);
			pending_vertices.push_back(v);
		endtask

		function void check_vertex(vertex_t got);
			vertex_t want;
			if (pending_vertices.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected vertex %h", got);
				return;
			end
			want = pending_vertices.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("vertex mismatch: expected pos %0d %0d %0d norm %0d %0d %0d tex %0d %0d",
						want.pos_x, want.pos_y, want.pos_z, want.norm_x, want.norm_y,
						want.norm_z, want.tex_u, want.tex_v);
					$display("                 got      pos %0d %0d %0d norm %0d %0d %0d tex %0d %0d",
						got.pos_x, got.pos_y, got.pos_z, got.norm_x, got.norm_y,
						got.norm_z, got.tex_u, got.tex_v);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [RAD_W-1:0] cfg_wdata = '0;

	tmvg_in_if  vtx_in ();
	tmvg_out_if vtx_out ();

	torus_mesh_vertex_gen_core i_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata), .vtx_in(vtx_in.sink), .vtx_out(vtx_out.source)
	);

	always #2 clk = ~clk;

	vertex_scoreboard board = new();
	int send_idle_pct = 0;   // percentage of cycles the sender holds back
	int recv_stall_pct = 0;  // percentage of cycles the receiver stalls
	int quiet_cycles = 0;
	bit request_done = 1'b0;

	initial begin
		vtx_in.valid = 1'b0;
		vtx_in.stack_index = '0;
		vtx_in.slice_index = '0;
		vtx_out.ready = 1'b0;
	end

	// Receiver: ready is redrawn at each falling edge, results are checked on the rising edge.
	always @(negedge clk)
		if (arst_n) vtx_out.ready <= ($urandom_range(99) >= recv_stall_pct);

	always @(posedge clk) begin
		vertex_t got;
		if (arst_n && vtx_out.valid && vtx_out.ready) begin
			got = '{vtx_out.pos_x, vtx_out.pos_y, vtx_out.pos_z, vtx_out.norm_x,
				vtx_out.norm_y, vtx_out.norm_z, vtx_out.tex_u, vtx_out.tex_v};
			board.check_vertex(got);
		end
	end

	// Watchdog: counts cycles in which no item moves on either channel.
	always @(posedge clk) begin
		if ((vtx_in.valid && vtx_in.ready) || (vtx_out.valid && vtx_out.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("** torus_mesh_vertex_gen_core: FAILED **");
			$finish;
		end
	end

	// Offers one grid vertex; the item is noted at the edge where it is accepted.
	// Valid stays high on return so that the next item can follow without a gap.
	task automatic send_vertex(input logic [9:0] stack_i, input logic [9:0] slice_i);
		while ($urandom_range(99) < send_idle_pct) begin
			vtx_in.valid <= 1'b0;
			@(negedge clk);
		end
		vtx_in.valid <= 1'b1;
		vtx_in.stack_index <= stack_i;
		vtx_in.slice_index <= slice_i;
		do @(posedge clk); while (!vtx_in.ready);
		board.note_request(stack_i, slice_i);
		@(negedge clk);
	endtask

	// Waits until every predicted vertex has come back, then a pipeline's worth more.
	task automatic drain_results();
		vtx_in.valid <= 1'b0;
		while (board.pending_vertices.size() != 0) @(negedge clk);
		repeat (PIPE_LAT + 8) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [15:0] d);
		cfg_we <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= d;
		@(negedge clk);
		board.write_reg(r, d);
	endtask

	task automatic set_mesh(input logic [15:0] ri, ro, input logic [9:0] ns, nt);
		drain_results();
		write_reg(REG_INNER_RADIUS, ri);
		write_reg(REG_OUTER_RADIUS, ro);
		write_reg(REG_SLICE_COUNT, {6'd0, ns});
		write_reg(REG_STACK_COUNT, {6'd0, nt});
		cfg_we <= 1'b0;
	endtask

	// Mostly in-range grid indices, with some past the counts to exercise saturation.
	task automatic random_vertices(input int n);
		logic [9:0] st, sl;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(9) < 7) begin
				st = 10'($urandom_range(board.used_count(board.stacks_q)));
				sl = 10'($urandom_range(board.used_count(board.slices_q)));
			end else begin
				st = 10'($urandom);
				sl = 10'($urandom);
			end
			send_vertex(st, sl);
		end
	endtask

	initial begin
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part with the reset registers: corners of the grid and overshoot.
		send_vertex(10'd0, 10'd0);
		send_vertex(10'd16, 10'd32);
		send_vertex(10'd8, 10'd16);
		send_vertex(10'd1023, 10'd1023);
		send_vertex(10'd4, 10'd8);
		send_vertex(10'd12, 10'd24);

		// Counts below three and at the top, inner above outer, largest radii.
		set_mesh(16'd512, 16'd256, 10'd0, 10'd2);
		send_vertex(10'd1, 10'd1);
		send_vertex(10'd2, 10'd2);
		send_vertex(10'd1023, 10'd0);
		set_mesh(16'hFFFF, 16'hFFFF, 10'd1023, 10'd1023);
		send_vertex(10'd0, 10'd0);
		send_vertex(10'd511, 10'd255);
		send_vertex(10'd1023, 10'd767);
		send_vertex(10'd1022, 10'd1);
		set_mesh(16'd0, 16'hFFFF, 10'd3, 10'd3);
		send_vertex(10'd0, 10'd1);
		send_vertex(10'd1, 10'd2);
		send_vertex(10'd3, 10'd3);
		set_mesh(16'hFFFF, 16'd0, 10'd7, 10'd5);
		send_vertex(10'd2, 10'd5);
		send_vertex(10'd0, 10'd3);

		// Random phases: each with new registers, cycling through four idling patterns.
		for (int ph = 0; ph < 8; ph++) begin
			set_mesh(16'($urandom), 16'($urandom), 10'($urandom), 10'($urandom));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
				default: begin send_idle_pct = 34; recv_stall_pct = 34; end
			endcase
			random_vertices(75);
			// Sender holds off until the pipeline is empty, then carries on.
			vtx_in.valid <= 1'b0;
			@(negedge clk);
			while (board.pending_vertices.size() != 0) @(negedge clk);
			random_vertices(80);
		end

		drain_results();
		if (board.mismatches == 0 && board.pending_vertices.size() == 0) begin
			$display("** torus_mesh_vertex_gen_core: PASSED **");
		end else begin
			$display("** torus_mesh_vertex_gen_core: FAILED **");
		end
		$finish;
	end
endmodule
